>>> rtl/ybd_pkg.sv
`default_nettype none

package ybd_pkg;

    // grid strides in pixels
    localparam int COARSE_STRIDE = 32;
    localparam int FINE_STRIDE   = 16;

    // log2(e) in Q16
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // stream widths
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 152;

    // sigmoid lane: magnitude, mantissa, denominator, divide steps, rounding
    localparam int DIV_STEPS  = 17;
    localparam int SIG_STAGES = DIV_STEPS + 4;

    // sigmoid lanes
    localparam int NUM_SIG  = 5;
    localparam int SIG_CX   = 0;
    localparam int SIG_CY   = 1;
    localparam int SIG_OBJ  = 2;
    localparam int SIG_CLS0 = 3;
    localparam int SIG_CLS1 = 4;

    // size path stages
    localparam int STG_LOG   = 1;
    localparam int STG_MANT  = 2;
    localparam int STG_SCALE = 3;
    localparam int STG_HALF  = 4;

    // register indexes
    localparam logic [2:0] REG_THRESHOLD       = 3'd0;
    localparam logic [2:0] REG_ANCHOR_FINE_0   = 3'd1;
    localparam logic [2:0] REG_ANCHOR_FINE_1   = 3'd2;
    localparam logic [2:0] REG_ANCHOR_FINE_2   = 3'd3;
    localparam logic [2:0] REG_ANCHOR_COARSE_0 = 3'd4;
    localparam logic [2:0] REG_ANCHOR_COARSE_1 = 3'd5;
    localparam logic [2:0] REG_ANCHOR_COARSE_2 = 3'd6;

    // register reset values
    localparam logic [15:0] THRESHOLD_RESET       = 16'd32768;
    localparam logic [19:0] ANCHOR_FINE_0_RESET   = 20'd10254;
    localparam logic [19:0] ANCHOR_FINE_1_RESET   = 20'd23579;
    localparam logic [19:0] ANCHOR_FINE_2_RESET   = 20'd37946;
    localparam logic [19:0] ANCHOR_COARSE_0_RESET = 20'd83026;
    localparam logic [19:0] ANCHOR_COARSE_1_RESET = 20'd138409;
    localparam logic [19:0] ANCHOR_COARSE_2_RESET = 20'd352575;

    localparam logic [32:0] POW2_CAP = 33'h1_0000_0000;

    typedef struct packed {
        logic        scale_select;
        logic [5:0]  cell_col;
        logic [5:0]  cell_row;
        logic [1:0]  anchor_slot;
        logic [15:0] raw_center_x;
        logic [15:0] raw_center_y;
        logic [15:0] raw_width;
        logic [15:0] raw_height;
        logic [15:0] raw_objectness;
        logic [15:0] raw_class_zero;
        logic [15:0] raw_class_one;
    } ybd_in_t;

    // geometry carried down the pipe next to the sigmoid lanes
    typedef struct packed {
        logic        fine;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [9:0]  anchor_w;
        logic [9:0]  anchor_h;
        logic [16:0] half_w;
        logic [16:0] half_h;
    } ybd_geo_t;

    // 2^(k/16) in Q16
    function automatic logic [17:0] pow2_tab(input logic [4:0] idx);
        logic [17:0] val;
        case (idx)
            5'd0:    val = 18'd65536;
            5'd1:    val = 18'd68438;
            5'd2:    val = 18'd71468;
            5'd3:    val = 18'd74632;
            5'd4:    val = 18'd77936;
            5'd5:    val = 18'd81386;
            5'd6:    val = 18'd84990;
            5'd7:    val = 18'd88752;
            5'd8:    val = 18'd92682;
            5'd9:    val = 18'd96785;
            5'd10:   val = 18'd101070;
            5'd11:   val = 18'd105545;
            5'd12:   val = 18'd110218;
            5'd13:   val = 18'd115098;
            5'd14:   val = 18'd120193;
            5'd15:   val = 18'd125515;
            default: val = 18'd131072;
        endcase
        return val;
    endfunction

    // 2^(f/65536) in Q16, interpolated between table points
    function automatic logic [16:0] pow2_mant(input logic [15:0] f);
        logic [17:0] lo;
        logic [17:0] hi;
        logic [12:0] diff;
        logic [25:0] prod;
        logic [17:0] m;
        lo   = pow2_tab({1'b0, f[15:12]});
        hi   = pow2_tab({1'b0, f[15:12]} + 5'd1);
        diff = 13'(hi - lo);
        prod = 26'(diff) * 26'(f[11:0]);
        m    = lo + 18'((prod + 26'd2048) >> 12);
        return 17'(m);
    endfunction

    // round-half-up right shift, k of zero passes m through
    function automatic logic [16:0] round_shr(input logic [16:0] m, input logic [8:0] k);
        logic [16:0] t;
        logic [16:0] res;
        t = m >> (k - 9'd1);
        if (k == 9'd0)
        begin
            res = m;
        end
        else
        begin
            res = 17'((18'(t) + 18'd1) >> 1);
        end
        return res;
    endfunction

    // Q7.8 logit to Q16 base-2 exponent, round-half-up rounding
    function automatic logic signed [24:0] log2_step(input logic signed [15:0] v);
        logic signed [33:0] prod;
        prod = v * $signed({1'b0, LOG2E_Q16});
        return 25'((prod + 34'sd128) >>> 8);
    endfunction

    // m * 2^n in Q16, saturated at 2^32
    function automatic logic [32:0] pow2_scale(input logic [16:0] m, input logic signed [8:0] n);
        logic [32:0] wide;
        logic [32:0] res;
        logic [8:0]  k;
        wide = 33'(m) << n[3:0];
        k    = 9'(-n);
        if (n[8])
        begin
            res = 33'(round_shr(m, k));
        end
        else if (n[7:0] >= 8'd16)
        begin
            res = POW2_CAP;
        end
        else
        begin
            res = (wide > POW2_CAP) ? POW2_CAP : wide;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/yolo_box_decode.sv
`default_nettype none

// Box decoder for one grid cell and anchor prediction per beat. Sigmoid is taken of the
// two centre offsets, objectness and both class logits; exp of the two size logits is
// scaled by the anchor picked from scale and slot (slot three reads as slot two). The
// result beat carries saturated Q11.4 corners, Q0.16 probabilities, the best class and
// the score; m_tuser is low and every tdata field zero when objectness is below the
// threshold. Throughput is one beat per clock while m_tready stays high, and the pipe
// depth is set by the 17-step restoring divider in each sigmoid lane. Every
// stage has its own valid bit and moves up when the stage after it is free, so gaps
// close up and a new beat is taken while a result waits at the output. Configuration
// writes take effect on the next clock and should only be made while the block is idle.
module yolo_box_decode (
    input  wire                             clk,
    input  wire                             rst_n,
    // input stream
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // cell_col, cell_row, anchor_slot, raw_center_x, raw_center_y, raw_width,
    // raw_height, raw_objectness, raw_class_zero, raw_class_one
    input  wire [ybd_pkg::IN_DATA_W-1:0]    s_tdata,
    // scale_select
    input  wire                             s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // box_left, box_top, box_right, box_bottom, objectness_prob, class_zero_prob,
    // class_one_prob, best_class, best_class_prob, detection_score
    output logic [ybd_pkg::OUT_DATA_W-1:0]  m_tdata,
    // detection_valid
    output logic                            m_tuser,
    // configuration write port
    input  wire                             cfg_wr_en,
    input  wire [2:0]                       cfg_addr,
    input  wire [19:0]                      cfg_wr_data
);

    // last pipeline stage ahead of the output register
    localparam int LAST = ybd_pkg::SIG_STAGES;

    // config registers
    logic [15:0] thr_reg;
    logic [19:0] anchor_reg [6];

    // stage handshake
    logic [LAST:0]   valid_reg;
    logic            out_valid_reg;
    logic [LAST+1:0] rdy;
    logic [LAST+1:0] ld;

    // stage 0 input register
    ybd_pkg::ybd_in_t in_reg;
    ybd_pkg::ybd_in_t in_next;

    // geometry pipe
    ybd_pkg::ybd_geo_t geo_reg [1:LAST];
    ybd_pkg::ybd_geo_t geo_in;
    ybd_pkg::ybd_geo_t geo_half;

    // size path, index 0 is width and 1 is height
    logic signed [24:0] ylog_reg [2];
    logic signed [8:0]  exp_n_reg [2];
    logic [16:0]        exp_m_reg [2];
    logic [32:0]        exp_e_reg [2];

    // sigmoid lanes
    logic signed [15:0] sig_raw  [ybd_pkg::NUM_SIG];
    logic [15:0]        sig_prob [ybd_pkg::NUM_SIG];

    // output register
    logic [ybd_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [ybd_pkg::OUT_DATA_W-1:0] out_data_next;
    logic                           det_reg;
    logic                           det_next;

    logic [2:0]  anchor_idx;
    logic [1:0]  slot_clip;
    logic [19:0] anchor_sel;
    logic [42:0] half_prod_w;
    logic [42:0] half_prod_h;
    logic [29:0] half_full_w;
    logic [29:0] half_full_h;

    logic [15:0] p_obj;
    logic [15:0] p_c0;
    logic [15:0] p_c1;
    logic        best;
    logic [15:0] best_p;
    logic [31:0] score_prod;
    logic [15:0] score;
    logic [6:0]  stride;
    logic [28:0] cx_full;
    logic [28:0] cy_full;
    logic [16:0] cx;
    logic [16:0] cy;
    ybd_pkg::ybd_geo_t geo_last;

    function automatic logic [15:0] sat16(input logic signed [18:0] v);
        logic [15:0] res;
        if (v > 19'sd32767)
        begin
            res = 16'h7fff;
        end
        else if (v < -19'sd32768)
        begin
            res = 16'h8000;
        end
        else
        begin
            res = v[15:0];
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= ybd_pkg::THRESHOLD_RESET;
            anchor_reg[0] <= ybd_pkg::ANCHOR_FINE_0_RESET;
            anchor_reg[1] <= ybd_pkg::ANCHOR_FINE_1_RESET;
            anchor_reg[2] <= ybd_pkg::ANCHOR_FINE_2_RESET;
            anchor_reg[3] <= ybd_pkg::ANCHOR_COARSE_0_RESET;
            anchor_reg[4] <= ybd_pkg::ANCHOR_COARSE_1_RESET;
            anchor_reg[5] <= ybd_pkg::ANCHOR_COARSE_2_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                ybd_pkg::REG_THRESHOLD:       thr_reg       <= cfg_wr_data[15:0];
                ybd_pkg::REG_ANCHOR_FINE_0:   anchor_reg[0] <= cfg_wr_data;
                ybd_pkg::REG_ANCHOR_FINE_1:   anchor_reg[1] <= cfg_wr_data;
                ybd_pkg::REG_ANCHOR_FINE_2:   anchor_reg[2] <= cfg_wr_data;
                ybd_pkg::REG_ANCHOR_COARSE_0: anchor_reg[3] <= cfg_wr_data;
                ybd_pkg::REG_ANCHOR_COARSE_1: anchor_reg[4] <= cfg_wr_data;
                ybd_pkg::REG_ANCHOR_COARSE_2: anchor_reg[5] <= cfg_wr_data;
                default: ;   // writes past the last register are dropped
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // stage handshake: a stage takes a beat when it is empty or its own beat moves on
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        rdy[LAST+1] = !out_valid_reg || m_tready;
        for (int s = LAST; s >= 0; s--)
        begin
            rdy[s] = !valid_reg[s] || rdy[s+1];
        end
        ld[0] = s_tvalid && rdy[0];
        for (int s = 1; s <= LAST + 1; s++)
        begin
            ld[s] = rdy[s] && valid_reg[s-1];
        end
    end

    assign s_tready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int s = 1; s <= LAST; s++)
            begin
                if (rdy[s])
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
            if (rdy[LAST+1])
            begin
                out_valid_reg <= valid_reg[LAST];
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // stage 0: input register
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        in_next.scale_select   = s_tuser;
        in_next.cell_col       = s_tdata[5:0];
        in_next.cell_row       = s_tdata[11:6];
        in_next.anchor_slot    = s_tdata[13:12];
        in_next.raw_center_x   = s_tdata[29:14];
        in_next.raw_center_y   = s_tdata[45:30];
        in_next.raw_width      = s_tdata[61:46];
        in_next.raw_height     = s_tdata[77:62];
        in_next.raw_objectness = s_tdata[93:78];
        in_next.raw_class_zero = s_tdata[109:94];
        in_next.raw_class_one  = s_tdata[125:110];
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            in_reg <= in_next;
        end
    end

    // ---------------------------------------------------------------------------------
    // anchor pick and geometry entering the pipe
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        slot_clip  = (in_reg.anchor_slot == 2'd3) ? 2'd2 : in_reg.anchor_slot;
        // fine anchors sit in the first three entries, coarse in the next three
        anchor_idx = (in_reg.scale_select ? 3'd0 : 3'd3) + 3'(slot_clip);
        anchor_sel = anchor_reg[anchor_idx];

        geo_in.fine     = in_reg.scale_select;
        geo_in.col      = in_reg.cell_col;
        geo_in.row      = in_reg.cell_row;
        geo_in.anchor_w = anchor_sel[19:10];
        geo_in.anchor_h = anchor_sel[9:0];
        geo_in.half_w   = '0;
        geo_in.half_h   = '0;
    end

    // ---------------------------------------------------------------------------------
    // size path: log2 step, mantissa, scale, then half size times anchor
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        half_prod_w = 43'(exp_e_reg[0]) * 43'(geo_reg[ybd_pkg::STG_SCALE].anchor_w);
        half_prod_h = 43'(exp_e_reg[1]) * 43'(geo_reg[ybd_pkg::STG_SCALE].anchor_h);
        half_full_w = 30'((half_prod_w + 43'd4096) >> 13);
        half_full_h = 30'((half_prod_h + 43'd4096) >> 13);

        // anything past 17 bits already drives every corner into saturation
        geo_half        = geo_reg[ybd_pkg::STG_SCALE];
        geo_half.half_w = (half_full_w > 30'd131071) ? 17'h1ffff : half_full_w[16:0];
        geo_half.half_h = (half_full_h > 30'd131071) ? 17'h1ffff : half_full_h[16:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld[ybd_pkg::STG_LOG])
        begin
            ylog_reg[0] <= ybd_pkg::log2_step(in_reg.raw_width);
            ylog_reg[1] <= ybd_pkg::log2_step(in_reg.raw_height);
        end
        for (int i = 0; i < 2; i++)
        begin
            if (ld[ybd_pkg::STG_MANT])
            begin
                exp_n_reg[i] <= ylog_reg[i][24:16];
                exp_m_reg[i] <= ybd_pkg::pow2_mant(ylog_reg[i][15:0]);
            end
            if (ld[ybd_pkg::STG_SCALE])
            begin
                exp_e_reg[i] <= ybd_pkg::pow2_scale(exp_m_reg[i], exp_n_reg[i]);
            end
        end

        if (ld[1])
        begin
            geo_reg[1] <= geo_in;
        end
        for (int s = 2; s <= LAST; s++)
        begin
            if (ld[s])
            begin
                geo_reg[s] <= (s == ybd_pkg::STG_HALF) ? geo_half : geo_reg[s-1];
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // sigmoid lanes, each lines up with stage LAST
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        sig_raw[ybd_pkg::SIG_CX]   = in_reg.raw_center_x;
        sig_raw[ybd_pkg::SIG_CY]   = in_reg.raw_center_y;
        sig_raw[ybd_pkg::SIG_OBJ]  = in_reg.raw_objectness;
        sig_raw[ybd_pkg::SIG_CLS0] = in_reg.raw_class_zero;
        sig_raw[ybd_pkg::SIG_CLS1] = in_reg.raw_class_one;
    end

    for (genvar g = 0; g < ybd_pkg::NUM_SIG; g++)
    begin : g_sig
        ybd_sigmoid u_sig (
            .clk  (clk),
            .en   (ld[LAST:1]),
            .raw  (sig_raw[g]),
            .prob (sig_prob[g])
        );
    end

    // ---------------------------------------------------------------------------------
    // final stage: threshold, best class, score, centre and corners
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        geo_last = geo_reg[LAST];
        p_obj    = sig_prob[ybd_pkg::SIG_OBJ];
        p_c0     = sig_prob[ybd_pkg::SIG_CLS0];
        p_c1     = sig_prob[ybd_pkg::SIG_CLS1];

        det_next   = p_obj >= thr_reg;
        // ties go to class zero
        best       = p_c1 > p_c0;
        best_p     = best ? p_c1 : p_c0;
        score_prod = 32'(p_obj) * 32'(best_p);
        score      = 16'((33'(score_prod) + 33'd32768) >> 16);

        stride  = geo_last.fine ? 7'(ybd_pkg::FINE_STRIDE) : 7'(ybd_pkg::COARSE_STRIDE);
        cx_full = (29'({geo_last.col, 16'h0000}) + 29'(sig_prob[ybd_pkg::SIG_CX]))
                  * 29'(stride);
        cy_full = (29'({geo_last.row, 16'h0000}) + 29'(sig_prob[ybd_pkg::SIG_CY]))
                  * 29'(stride);
        cx      = 17'((cx_full + 29'd2048) >> 12);
        cy      = 17'((cy_full + 29'd2048) >> 12);

        if (det_next)
        begin
            out_data_next = {
                7'b0,
                score,
                best_p,
                best,
                p_c1,
                p_c0,
                p_obj,
                sat16($signed({2'b00, cy}) + $signed({2'b00, geo_last.half_h})),
                sat16($signed({2'b00, cx}) + $signed({2'b00, geo_last.half_w})),
                sat16($signed({2'b00, cy}) - $signed({2'b00, geo_last.half_h})),
                sat16($signed({2'b00, cx}) - $signed({2'b00, geo_last.half_w}))
            };
        end
        else
        begin
            out_data_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[LAST+1])
        begin
            out_data_reg <= out_data_next;
            det_reg      <= det_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = det_reg;

endmodule

`default_nettype wire

>>> rtl/ybd_sigmoid.sv
`default_nettype none

// pipelined sigmoid, Q7.8 in, Q0.16 out, one stage per enable bit
module ybd_sigmoid (
    input  wire                                clk,
    input  wire [ybd_pkg::SIG_STAGES-1:0]      en,
    input  wire signed [15:0]                  raw,
    output logic [15:0]                        prob
);

    logic [23:0] mag_reg;
    logic [ybd_pkg::SIG_STAGES-2:0] neg_reg;
    logic [16:0] mant_reg;
    logic [8:0]  shift_reg;
    logic [17:0] den_reg [0:ybd_pkg::DIV_STEPS];
    logic [16:0] rem_reg [0:ybd_pkg::DIV_STEPS];
    logic [16:0] quo_reg [0:ybd_pkg::DIV_STEPS];
    logic [15:0] prob_reg;

    logic [15:0] abs_val;
    logic [32:0] mag_prod;
    logic [15:0] frac;
    logic [16:0] e_val;
    logic [17:0] half_lo;
    logic [17:0] half_hi;
    logic [17:0] p_val;

    always_comb
    begin
        abs_val  = raw[15] ? 16'(-raw) : 16'(raw);
        mag_prod = 33'(abs_val) * 33'(ybd_pkg::LOG2E_Q16);
        // exponent is -mag: fraction is the two's complement of the low bits
        frac     = ~mag_reg[15:0] + 16'd1;
        e_val    = ybd_pkg::round_shr(mant_reg, shift_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mag_reg    <= 24'((mag_prod + 33'd128) >> 8);
            neg_reg[0] <= raw[15];
        end
        if (en[1])
        begin
            mant_reg  <= ybd_pkg::pow2_mant(frac);
            shift_reg <= 9'(mag_reg[23:16]) + 9'(frac != 16'd0);
        end
        if (en[2])
        begin
            den_reg[0] <= 18'd65536 + 18'(e_val);
            rem_reg[0] <= 17'd32768;
            quo_reg[0] <= 17'd0;
        end
        for (int s = 1; s <= ybd_pkg::SIG_STAGES - 2; s++)
        begin
            if (en[s])
            begin
                neg_reg[s] <= neg_reg[s-1];
            end
        end
    end

    // restoring divide of 2^32 by the denominator, one quotient bit per stage
    for (genvar j = 1; j <= ybd_pkg::DIV_STEPS; j++)
    begin : g_div
        logic [17:0] rem_sh;
        logic        ge;

        always_comb
        begin
            rem_sh = {rem_reg[j-1], 1'b0};
            ge     = rem_sh >= den_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en[2+j])
            begin
                den_reg[j] <= den_reg[j-1];
                rem_reg[j] <= ge ? 17'(rem_sh - den_reg[j-1]) : rem_sh[16:0];
                quo_reg[j] <= {quo_reg[j-1][15:0], ge};
            end
        end
    end

    // rounding from the remainder, negative side is 1 - p
    always_comb
    begin
        half_lo = {1'b0, den_reg[ybd_pkg::DIV_STEPS][17:1]};
        half_hi = den_reg[ybd_pkg::DIV_STEPS] - half_lo;
        if (neg_reg[ybd_pkg::SIG_STAGES-2])
        begin
            p_val = 18'd65536 - 18'(quo_reg[ybd_pkg::DIV_STEPS])
                    - 18'(18'(rem_reg[ybd_pkg::DIV_STEPS]) > half_lo);
        end
        else
        begin
            p_val = 18'(quo_reg[ybd_pkg::DIV_STEPS])
                    + 18'(18'(rem_reg[ybd_pkg::DIV_STEPS]) >= half_hi);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ybd_pkg::SIG_STAGES-1])
        begin
            prob_reg <= (p_val > 18'd65535) ? 16'hffff : p_val[15:0];
        end
    end

    assign prob = prob_reg;

endmodule

`default_nettype wire

>>> tb/tb_yolo_box_decode.sv
`timescale 1ns / 100ps

module tb_yolo_box_decode;

    // fixed-point constants of the decode math
    localparam longint LOG2E = 94548;
    localparam longint unsigned POW2_LIMIT = 64'h1_0000_0000;
    localparam longint unsigned EXP2_Q16 [0:16] = '{
        65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
        96785, 101070, 105545, 110218, 115098, 120193, 125515, 131072
    };

    // cycles to let the pipe settle after the last result, and the watchdog bound
    localparam int SETTLE_CYCLES = 30;
    localparam int QUIET_LIMIT   = 3000;
    // long output hold-off so the pipe fills and backs up into the input
    localparam int HOLD_AT_CELL  = 300;
    localparam int HOLD_CYCLES   = 400;

    // one decoded box as it leaves the block
    typedef struct packed {
        logic        detection_valid;
        logic [15:0] box_left;
        logic [15:0] box_top;
        logic [15:0] box_right;
        logic [15:0] box_bottom;
        logic [15:0] objectness_prob;
        logic [15:0] class_zero_prob;
        logic [15:0] class_one_prob;
        logic        best_class;
        logic [15:0] best_class_prob;
        logic [15:0] detection_score;
    } box_result_t;

    // one cell waiting to be sent, with its lead-in gap
    typedef struct {
        ybd_pkg::ybd_in_t item;
        int unsigned      gap;
        bit               drain;
    } cell_job_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ybd_pkg::IN_DATA_W-1:0]   s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [ybd_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                            m_tuser;
    logic                            cfg_wr_en = 1'b0;
    logic [2:0]                      cfg_addr = '0;
    logic [19:0]                     cfg_wr_data = '0;

    // predictor copy of the register file
    logic [15:0] thresh_q;
    logic [19:0] anchor_q [0:5];

    cell_job_t        pending_cells [$];
    box_result_t      expected_boxes [$];
    ybd_pkg::ybd_in_t cur_cell;

    int unsigned cells_queued = 0;
    int unsigned cells_in = 0;
    int unsigned boxes_seen = 0;
    int unsigned gap_count = 0;
    int unsigned fail_cnt = 0;
    int unsigned quiet_cycles = 0;

    // output side pacing
    logic        sink_rdy = 1'b0;
    int unsigned stall_left = 0;
    int unsigned stall_draw;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    box_result_t seen_box;

    assign m_tready = sink_rdy && (hold_left == 0);

    yolo_box_decode dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // decode predictor
    // ------------------------------------------------------------------

    // 2^y with y in Q16, result Q16 capped at 2^32
    function automatic longint unsigned pow2_fixed(input longint y);
        longint            n;
        longint            k;
        longint unsigned   frac;
        longint unsigned   idx;
        longint unsigned   rem;
        longint unsigned   mant;
        longint unsigned   shifted;
        n    = y >>> 16;
        frac = y & 64'hFFFF;
        idx  = frac >> 12;
        rem  = frac & 64'hFFF;
        // linear interpolation between the sixteenth-octave points
        mant = EXP2_Q16[idx] + (((EXP2_Q16[idx + 1] - EXP2_Q16[idx]) * rem + 2048) >> 12);
        if (n >= 16)
        begin
            return POW2_LIMIT;
        end
        if (n >= 0)
        begin
            shifted = mant << n;
            return (shifted > POW2_LIMIT) ? POW2_LIMIT : shifted;
        end
        k = -n;
        if (k > 40)
        begin
            return 0;
        end
        return (mant + (64'd1 << (k - 1))) >> k;
    endfunction

    // logistic of a Q7.8 logit, Q0.16, pinned below one
    function automatic logic [15:0] logistic_q16(input logic signed [15:0] raw);
        longint          mag;
        longint unsigned e;
        longint unsigned d;
        longint unsigned p;
        mag = (raw < 0) ? -longint'(raw) : longint'(raw);
        mag = (mag * LOG2E + 128) >>> 8;
        e   = pow2_fixed(-mag);
        d   = 64'd65536 + e;
        if (raw >= 0)
        begin
            p = (POW2_LIMIT + d / 2) / d;
        end
        else
        begin
            p = (e * 65536 + d / 2) / d;
        end
        return (p > 65535) ? 16'hFFFF : p[15:0];
    endfunction

    function automatic longint unsigned exp_fixed(input logic signed [15:0] raw);
        return pow2_fixed((longint'(raw) * LOG2E + 128) >>> 8);
    endfunction

    function automatic logic [15:0] clamp16(input longint v);
        if (v > 32767)
        begin
            return 16'h7FFF;
        end
        if (v < -32768)
        begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function automatic box_result_t decode_box(input ybd_pkg::ybd_in_t c);
        box_result_t     res;
        logic [15:0]     obj;
        logic [15:0]     c0;
        logic [15:0]     c1;
        logic [15:0]     best_p;
        logic [19:0]     anchor;
        int              slot;
        longint unsigned stride;
        longint unsigned ew;
        longint unsigned eh;
        longint          cx;
        longint          cy;
        longint          hw;
        longint          hh;
        res = '0;
        obj = logistic_q16(c.raw_objectness);
        c0  = logistic_q16(c.raw_class_zero);
        c1  = logistic_q16(c.raw_class_one);
        // weak objectness gives an all-zero beat
        if (obj < thresh_q)
        begin
            return res;
        end
        best_p = (c1 > c0) ? c1 : c0;
        // slot three aliases slot two
        slot   = (c.anchor_slot > 2'd2) ? 2 : int'(c.anchor_slot);
        anchor = c.scale_select ? anchor_q[slot] : anchor_q[3 + slot];
        stride = c.scale_select ? ybd_pkg::FINE_STRIDE : ybd_pkg::COARSE_STRIDE;
        cx = longint'((((longint'(c.cell_col) << 16) + logistic_q16(c.raw_center_x)) * stride
                       + 2048) >> 12);
        cy = longint'((((longint'(c.cell_row) << 16) + logistic_q16(c.raw_center_y)) * stride
                       + 2048) >> 12);
        ew = exp_fixed(c.raw_width);
        eh = exp_fixed(c.raw_height);
        hw = longint'((ew * anchor[19:10] + 4096) >> 13);
        hh = longint'((eh * anchor[9:0] + 4096) >> 13);
        res.detection_valid = 1'b1;
        res.box_left        = clamp16(cx - hw);
        res.box_top         = clamp16(cy - hh);
        res.box_right       = clamp16(cx + hw);
        res.box_bottom      = clamp16(cy + hh);
        res.objectness_prob = obj;
        res.class_zero_prob = c0;
        res.class_one_prob  = c1;
        res.best_class      = (c1 > c0);
        res.best_class_prob = best_p;
        res.detection_score = 16'(((longint'(obj) * longint'(best_p)) + 32768) >> 16);
        return res;
    endfunction

    function automatic logic [ybd_pkg::IN_DATA_W-1:0] pack_cell(input ybd_pkg::ybd_in_t c);
        return {2'b00, c.raw_class_one, c.raw_class_zero, c.raw_objectness, c.raw_height,
                c.raw_width, c.raw_center_y, c.raw_center_x, c.anchor_slot, c.cell_row,
                c.cell_col};
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
        fail_cnt++;
        if (fail_cnt <= 10)
        begin
            $display("mismatch at %0t: %s expected %0h actual %0h", $realtime, what, want, got);
        end
    endtask

    task automatic check_box(input box_result_t want, input box_result_t got);
        if (want.detection_valid != got.detection_valid)
            flag_mismatch("detection_valid", want.detection_valid, got.detection_valid);
        if (want.box_left != got.box_left)
            flag_mismatch("box_left", want.box_left, got.box_left);
        if (want.box_top != got.box_top)
            flag_mismatch("box_top", want.box_top, got.box_top);
        if (want.box_right != got.box_right)
            flag_mismatch("box_right", want.box_right, got.box_right);
        if (want.box_bottom != got.box_bottom)
            flag_mismatch("box_bottom", want.box_bottom, got.box_bottom);
        if (want.objectness_prob != got.objectness_prob)
            flag_mismatch("objectness_prob", want.objectness_prob, got.objectness_prob);
        if (want.class_zero_prob != got.class_zero_prob)
            flag_mismatch("class_zero_prob", want.class_zero_prob, got.class_zero_prob);
        if (want.class_one_prob != got.class_one_prob)
            flag_mismatch("class_one_prob", want.class_one_prob, got.class_one_prob);
        if (want.best_class != got.best_class)
            flag_mismatch("best_class", want.best_class, got.best_class);
        if (want.best_class_prob != got.best_class_prob)
            flag_mismatch("best_class_prob", want.best_class_prob, got.best_class_prob);
        if (want.detection_score != got.detection_score)
            flag_mismatch("detection_score", want.detection_score, got.detection_score);
    endtask

    // ------------------------------------------------------------------
    // input driver: takes cells off the pending queue, honors gaps and drains
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= 1'b0;
            gap_count <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_boxes = {expected_boxes, decode_box(cur_cell)};
                cells_in <= cells_in + 1;
            end
            // the current beat is gone or never was, so the slot is free
            if (!s_tvalid || s_tready)
            begin
                if (pending_cells.size() != 0 && gap_count >= pending_cells[0].gap &&
                    (!pending_cells[0].drain || expected_boxes.size() == 0))
                begin
                    cur_cell = pending_cells[0].item;
                    void'(pending_cells.pop_front());
                    s_tvalid  <= 1'b1;
                    s_tdata   <= pack_cell(cur_cell);
                    s_tuser   <= cur_cell.scale_select;
                    gap_count <= 0;
                end
                else
                begin
                    s_tvalid  <= 1'b0;
                    gap_count <= gap_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output monitor: random stalls per beat, calm stretches in between
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_rdy   <= 1'b0;
            stall_left <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            seen_box.detection_valid = m_tuser;
            seen_box.box_left        = m_tdata[15:0];
            seen_box.box_top         = m_tdata[31:16];
            seen_box.box_right       = m_tdata[47:32];
            seen_box.box_bottom      = m_tdata[63:48];
            seen_box.objectness_prob = m_tdata[79:64];
            seen_box.class_zero_prob = m_tdata[95:80];
            seen_box.class_one_prob  = m_tdata[111:96];
            seen_box.best_class      = m_tdata[112];
            seen_box.best_class_prob = m_tdata[128:113];
            seen_box.detection_score = m_tdata[144:129];
            if (expected_boxes.size() == 0)
            begin
                flag_mismatch("result beat with nothing pending", 0, m_tdata[63:0]);
            end
            else
            begin
                check_box(expected_boxes.pop_front(), seen_box);
            end
            boxes_seen++;
            // every third stretch of fifty beats runs with no back-pressure
            stall_draw = (((boxes_seen / 50) % 3) == 1) ? 0 : $urandom_range(0, 14);
            if (stall_draw == 0)
            begin
                sink_rdy <= 1'b1;
            end
            else
            begin
                sink_rdy   <= 1'b0;
                stall_left <= stall_draw;
            end
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
            begin
                sink_rdy <= 1'b1;
            end
        end
        else
        begin
            sink_rdy <= 1'b1;
        end
    end

    // one long output hold-off while the sender keeps going
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && cells_in >= HOLD_AT_CELL)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("yolo_box_decode regression: fail");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic queue_cell(input ybd_pkg::ybd_in_t c, input bit drain);
        cell_job_t job;
        job.item  = c;
        // every third stretch of forty cells goes back to back
        job.gap   = (((cells_queued / 40) % 3) == 2) ? 0 : $urandom_range(0, 14);
        job.drain = drain;
        pending_cells = {pending_cells, job};
        cells_queued++;
    endtask

    task automatic send_cell(input logic sc, input logic [5:0] col, input logic [5:0] row,
                             input logic [1:0] slot, input logic [15:0] ox, input logic [15:0] oy,
                             input logic [15:0] lw, input logic [15:0] lh, input logic [15:0] obj,
                             input logic [15:0] k0, input logic [15:0] k1);
        ybd_pkg::ybd_in_t c;
        c.scale_select   = sc;
        c.cell_col       = col;
        c.cell_row       = row;
        c.anchor_slot    = slot;
        c.raw_center_x   = ox;
        c.raw_center_y   = oy;
        c.raw_width      = lw;
        c.raw_height     = lh;
        c.raw_objectness = obj;
        c.raw_class_zero = k0;
        c.raw_class_one  = k1;
        queue_cell(c, 1'b0);
    endtask

    function automatic logic [15:0] rand_logit();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(0, 4095)) - 16'd2048;
            2: v = 16'($urandom_range(0, 1023)) - 16'd512;
            default:
            begin
                case ($urandom_range(0, 3))
                    0: v = 16'h8000;
                    1: v = 16'h7FFF;
                    2: v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    // mostly plausible detections with random content, some pure noise
    function automatic ybd_pkg::ybd_in_t random_cell();
        ybd_pkg::ybd_in_t c;
        int unsigned      obj_lo;
        c.scale_select = 1'($urandom);
        c.cell_col     = 6'($urandom);
        c.cell_row     = 6'($urandom);
        c.anchor_slot  = 2'($urandom);
        if ($urandom_range(0, 99) < 15)
        begin
            c.raw_center_x   = 16'($urandom);
            c.raw_center_y   = 16'($urandom);
            c.raw_width      = 16'($urandom);
            c.raw_height     = 16'($urandom);
            c.raw_objectness = 16'($urandom);
            c.raw_class_zero = 16'($urandom);
            c.raw_class_one  = 16'($urandom);
        end
        else
        begin
            // a very high threshold only lets through saturated objectness
            obj_lo = (thresh_q > 16'd60000) ? 3000 : 0;
            c.raw_center_x   = rand_logit();
            c.raw_center_y   = rand_logit();
            c.raw_width      = ($urandom_range(0, 9) == 0) ? rand_logit()
                             : 16'($urandom_range(0, 2047)) - 16'd1024;
            c.raw_height     = ($urandom_range(0, 9) == 0) ? rand_logit()
                             : 16'($urandom_range(0, 2047)) - 16'd1024;
            c.raw_objectness = 16'($urandom_range(obj_lo, obj_lo + 3000));
            c.raw_class_zero = rand_logit();
            c.raw_class_one  = ($urandom_range(0, 7) == 0) ? c.raw_class_zero : rand_logit();
        end
        return c;
    endfunction

    task automatic queue_random(input int unsigned count);
        for (int unsigned n = 0; n < count; n++)
        begin
            queue_cell(random_cell(), $urandom_range(0, 79) == 0);
        end
    endtask

    task automatic wait_idle();
        while (boxes_seen != cells_queued)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        if (idx == ybd_pkg::REG_THRESHOLD)
        begin
            thresh_q = val[15:0];
        end
        else
        begin
            anchor_q[idx - 1] = val;
        end
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] thr, input logic [19:0] f0,
                                  input logic [19:0] f1, input logic [19:0] f2,
                                  input logic [19:0] k0, input logic [19:0] k1,
                                  input logic [19:0] k2);
        write_reg(ybd_pkg::REG_THRESHOLD, {4'h0, thr});
        write_reg(ybd_pkg::REG_ANCHOR_FINE_0, f0);
        write_reg(ybd_pkg::REG_ANCHOR_FINE_1, f1);
        write_reg(ybd_pkg::REG_ANCHOR_FINE_2, f2);
        write_reg(ybd_pkg::REG_ANCHOR_COARSE_0, k0);
        write_reg(ybd_pkg::REG_ANCHOR_COARSE_1, k1);
        write_reg(ybd_pkg::REG_ANCHOR_COARSE_2, k2);
    endtask

    initial
    begin
        thresh_q    = ybd_pkg::THRESHOLD_RESET;
        anchor_q[0] = ybd_pkg::ANCHOR_FINE_0_RESET;
        anchor_q[1] = ybd_pkg::ANCHOR_FINE_1_RESET;
        anchor_q[2] = ybd_pkg::ANCHOR_FINE_2_RESET;
        anchor_q[3] = ybd_pkg::ANCHOR_COARSE_0_RESET;
        anchor_q[4] = ybd_pkg::ANCHOR_COARSE_1_RESET;
        anchor_q[5] = ybd_pkg::ANCHOR_COARSE_2_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed cells at reset settings
        // zero objectness sits exactly on the default threshold, classes tie
        send_cell(1'b0, 6'd0, 6'd0, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'h0000, 16'h0000, 16'h0000);
        // objectness logit one lsb below zero, just under the threshold
        send_cell(1'b0, 6'd5, 6'd9, 2'd1, 16'h0100, 16'h0100, 16'h0100, 16'h0100,
                  16'hFFFF, 16'h0100, 16'h0200);
        // everything at max: saturated probabilities and huge boxes, slot three
        send_cell(1'b1, 6'd63, 6'd63, 2'd3, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                  16'h7FFF, 16'h7FFF, 16'h7FFF);
        // most negative offsets and sizes with a strong object
        send_cell(1'b0, 6'd63, 6'd63, 2'd3, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  16'h7FFF, 16'h8000, 16'h8000);
        // everything at min: no detection
        send_cell(1'b1, 6'd0, 6'd0, 2'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  16'h8000, 16'h8000, 16'h8000);
        // class one wins, class zero wins, saturated tie
        send_cell(1'b1, 6'd12, 6'd7, 2'd0, 16'h0080, 16'hFF80, 16'h0040, 16'hFFC0,
                  16'h0400, 16'h0100, 16'h0200);
        send_cell(1'b1, 6'd12, 6'd7, 2'd1, 16'h0080, 16'hFF80, 16'h0040, 16'hFFC0,
                  16'h0400, 16'h0200, 16'h0100);
        send_cell(1'b0, 6'd3, 6'd30, 2'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'h0400, 16'h7FFF, 16'h7FFF);
        // every slot on both scales
        for (int s = 0; s < 2; s++)
        begin
            for (int a = 0; a < 4; a++)
            begin
                send_cell(1'(s), 6'(a * 9), 6'(a * 13), 2'(a), 16'h0123, 16'hFE80,
                          16'h00C0, 16'hFF40, 16'h0300, 16'hFF00, 16'h0080);
            end
        end
        // size logits around the exp saturation point
        send_cell(1'b0, 6'd20, 6'd20, 2'd2, 16'h0000, 16'h0000, 16'h0B17, 16'h0B18,
                  16'h0200, 16'h0000, 16'h0000);
        send_cell(1'b1, 6'd0, 6'd63, 2'd0, 16'h7FFF, 16'h8000, 16'h0C00, 16'hF400,
                  16'h0001, 16'h0001, 16'hFFFF);
        send_cell(1'b0, 6'd63, 6'd0, 2'd1, 16'h8000, 16'h7FFF, 16'hF000, 16'h0A00,
                  16'h0800, 16'hC000, 16'h4000);
        queue_random(100);
        // hold the next cell until the pipe has emptied
        queue_cell(random_cell(), 1'b1);
        queue_random(99);
        wait_idle();

        // threshold zero, widest anchors: every cell is a detection
        apply_settings(16'd0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        queue_random(170);
        wait_idle();

        // top threshold, zero anchors
        apply_settings(16'hFFFF, 20'h0, 20'h0, 20'h0, 20'h0, 20'h0, 20'h0);
        queue_random(100);
        wait_idle();

        // random register values
        apply_settings(16'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                       20'($urandom), 20'($urandom), 20'($urandom));
        queue_random(120);
        wait_idle();

        // back to the power-on values
        apply_settings(ybd_pkg::THRESHOLD_RESET, ybd_pkg::ANCHOR_FINE_0_RESET,
                       ybd_pkg::ANCHOR_FINE_1_RESET, ybd_pkg::ANCHOR_FINE_2_RESET,
                       ybd_pkg::ANCHOR_COARSE_0_RESET, ybd_pkg::ANCHOR_COARSE_1_RESET,
                       ybd_pkg::ANCHOR_COARSE_2_RESET);
        queue_random(100);
        wait_idle();

        if (fail_cnt == 0)
        begin
            $display("yolo_box_decode regression: pass");
        end
        else
        begin
            $display("yolo_box_decode regression: fail");
        end
        $finish;
    end

endmodule
